FILE: design/trsa_pkg.sv
`default_nettype none

package trsa_pkg;

   localparam int INDEX_W    = 4;
   localparam int RANK_OUT_W = 6;
   localparam int SUM_W      = 17;
   localparam int DS_W       = 12;
   localparam int CFG_W      = 5;

   localparam logic [SUM_W-1:0] SUM_MAX   = {SUM_W{1'b1}};
   localparam logic [DS_W-1:0]  DS_MAX    = {DS_W{1'b1}};
   localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RANK,
      ST_FINISH,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
      logic finish;
      logic shift;
   } cell_ctl_type;

endpackage

`default_nettype wire

FILE: design/trsa_cell.sv
`default_nettype none

module trsa_cell import trsa_pkg::*; #(
   parameter int MAX_MODELS = 16,
   parameter int SCORE_BITS = 16
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire  cell_ctl_type                    ctl,
   input  wire                                   active,
   input  wire                                   wr_en,
   input  wire  [SCORE_BITS-1:0]                 wr_score,
   input  wire  [SCORE_BITS-1:0]                 nbr_score,
   input  wire                                   nbr_valid,
   output logic [SCORE_BITS-1:0]                 rot_score_out,
   output logic                                  rot_valid_out,
   input  wire  [((($clog2(2*MAX_MODELS+1)) > RANK_OUT_W) ?
                  $clog2(2*MAX_MODELS+1) : RANK_OUT_W)-1:0] chain_rank,
   input  wire  [SUM_W-1:0]                      chain_sum,
   output logic [((($clog2(2*MAX_MODELS+1)) > RANK_OUT_W) ?
                  $clog2(2*MAX_MODELS+1) : RANK_OUT_W)-1:0] emit_rank_out,
   output logic [SUM_W-1:0]                      emit_sum_out
);

   localparam int CNT_W  = $clog2(MAX_MODELS+1);
   localparam int RANK_W = (($clog2(2*MAX_MODELS+1)) > RANK_OUT_W) ?
                           $clog2(2*MAX_MODELS+1) : RANK_OUT_W;
   localparam int SUMX_W = SUM_W + 1;

   logic [SCORE_BITS-1:0] score_ff, score_in;
   logic [SCORE_BITS-1:0] rot_score_ff, rot_score_in;
   logic                  rot_valid_ff, rot_valid_in;
   logic [CNT_W-1:0]      greater_ff, greater_in;
   logic [CNT_W-1:0]      equal_ff, equal_in;
   logic [SUM_W-1:0]      sum_ff, sum_in;
   logic [RANK_W-1:0]     emit_rank_ff, emit_rank_in;
   logic [SUM_W-1:0]      emit_sum_ff, emit_sum_in;
   logic [RANK_W-1:0]     rank;
   logic [SUMX_W-1:0]     sum_wide;
   logic [SUM_W-1:0]      sum_sat;

   always_comb begin
      rank     = (RANK_W'(greater_ff) << 1) + RANK_W'(equal_ff) + RANK_W'(1);
      sum_wide = SUMX_W'(sum_ff) + SUMX_W'(rank);
      sum_sat  = (sum_wide > SUMX_W'(SUM_MAX)) ? SUM_MAX : sum_wide[SUM_W-1:0];
   end

   always_comb begin
      score_in     = wr_en ? wr_score : score_ff;
      rot_score_in = rot_score_ff;
      rot_valid_in = rot_valid_ff;
      greater_in   = greater_ff;
      equal_in     = equal_ff;
      sum_in       = sum_ff;
      emit_rank_in = emit_rank_ff;
      emit_sum_in  = emit_sum_ff;
      if (ctl.load) begin
         rot_score_in = score_in;
         rot_valid_in = active;
         greater_in   = '0;
         equal_in     = '0;
      end
      if (ctl.step) begin
         rot_score_in = nbr_score;
         rot_valid_in = nbr_valid;
         if (rot_valid_ff && (rot_score_ff > score_ff)) begin
            greater_in = greater_ff + CNT_W'(1);
         end
         if (rot_valid_ff && (rot_score_ff == score_ff)) begin
            equal_in = equal_ff + CNT_W'(1);
         end
      end
      if (ctl.finish) begin
         if (active) begin
            sum_in = sum_sat;
         end
         emit_rank_in = rank;
         emit_sum_in  = sum_sat;
      end
      if (ctl.shift) begin
         emit_rank_in = chain_rank;
         emit_sum_in  = chain_sum;
      end
   end

   always_ff @(posedge clock) begin
      score_ff     <= score_in;
      rot_score_ff <= rot_score_in;
      greater_ff   <= greater_in;
      equal_ff     <= equal_in;
      emit_rank_ff <= emit_rank_in;
      emit_sum_ff  <= emit_sum_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rot_valid_ff <= 1'b0;
         sum_ff       <= '0;
      end else begin
         rot_valid_ff <= rot_valid_in;
         sum_ff       <= sum_in;
      end
   end

   assign rot_score_out = rot_score_ff;
   assign rot_valid_out = rot_valid_ff;
   assign emit_rank_out = emit_rank_ff;
   assign emit_sum_out  = emit_sum_ff;

endmodule

`default_nettype wire

FILE: design/tied_rank_sum_accumulator_top.sv
// Channel   Direction  Handshake              Beat contents
// req_      in         req_valid / req_stall  model index, score, last-in-dataset flag
// rsp_      out        rsp_valid / rsp_stall  model id, doubled rank, doubled rank sum,
//                                             datasets seen, last-of-run flag
// csr_      in         csr_valid / csr_ready  model count
//
// Score beats that are not last are taken while idle and can arrive back to back.
// A last beat starts a ranking pass while the scores rotate once around the ring
// of cells, then a finish step, then one result per active model, one per cycle
// when rsp_stall stays low.
// req_stall is high from the last beat until the final result is loaded.
// Reset clears the rank sums and the dataset count and sets the model count to 16.
`default_nettype none

module tied_rank_sum_accumulator_top import trsa_pkg::*; #(
   parameter int MAX_MODELS = 16,
   parameter int SCORE_BITS = 16
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_stall,
   input  wire  [INDEX_W-1:0]    req_model_index,
   input  wire  [SCORE_BITS-1:0] req_score,
   input  wire                   req_last_in_dataset,
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   output logic [INDEX_W-1:0]    rsp_model_id,
   output logic [RANK_OUT_W-1:0] rsp_rank_doubled,
   output logic [SUM_W-1:0]      rsp_rank_sum_doubled,
   output logic [DS_W-1:0]       rsp_datasets_seen,
   output logic                  rsp_last_of_run,
   input  wire                   csr_valid,
   output logic                  csr_ready,
   input  wire  [CFG_W-1:0]      csr_data
);

   localparam int IDX_W  = $clog2(MAX_MODELS);
   localparam int NCNT_W = $clog2(MAX_MODELS+1);
   localparam int RANK_W = (($clog2(2*MAX_MODELS+1)) > RANK_OUT_W) ?
                           $clog2(2*MAX_MODELS+1) : RANK_OUT_W;

   state_type             state_ff, state_in;
   logic [IDX_W-1:0]      step_ff, step_in;
   logic [IDX_W-1:0]      emit_idx_ff, emit_idx_in;
   logic [CFG_W-1:0]      model_count_ff, model_count_in;
   logic [DS_W-1:0]       ds_count_ff, ds_count_in;
   logic [NCNT_W-1:0]     n_eff;
   logic                  req_take, csr_take, rsp_take, emit_last;
   cell_ctl_type          ctl;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [INDEX_W-1:0]    rsp_model_id_ff, rsp_model_id_in;
   logic [RANK_OUT_W-1:0] rsp_rank_ff, rsp_rank_in;
   logic [SUM_W-1:0]      rsp_sum_ff, rsp_sum_in;
   logic [DS_W-1:0]       rsp_ds_ff, rsp_ds_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic [SCORE_BITS-1:0] rot_score [MAX_MODELS];
   logic                  rot_valid [MAX_MODELS];
   logic [RANK_W-1:0]     emit_rank [MAX_MODELS+1];
   logic [SUM_W-1:0]      emit_sum  [MAX_MODELS+1];

   always_comb begin
      if (model_count_ff == '0) begin
         n_eff = NCNT_W'(1);
      end else if (int'(model_count_ff) > MAX_MODELS) begin
         n_eff = NCNT_W'(MAX_MODELS);
      end else begin
         n_eff = NCNT_W'(model_count_ff);
      end
   end

   assign req_take  = req_valid && !req_stall;
   assign csr_take  = csr_valid && csr_ready;
   assign rsp_take  = (state_ff == ST_EMIT) && (!rsp_valid_ff || !rsp_stall);
   assign emit_last = (int'(emit_idx_ff) + 1) == int'(n_eff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take && req_last_in_dataset) begin
               state_in = ST_RANK;
            end
         end
         ST_RANK: begin
            if (step_ff == IDX_W'(MAX_MODELS-1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_take && emit_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_stall  = (state_ff != ST_IDLE);
      csr_ready  = (state_ff == ST_IDLE);
      ctl.load   = req_take && req_last_in_dataset;
      ctl.step   = (state_ff == ST_RANK);
      ctl.finish = (state_ff == ST_FINISH);
      ctl.shift  = rsp_take;
   end

   always_comb begin
      step_in        = (state_ff == ST_RANK) ? step_ff + IDX_W'(1) : '0;
      emit_idx_in    = emit_idx_ff;
      model_count_in = csr_take ? csr_data : model_count_ff;
      ds_count_in    = ds_count_ff;
      if (ctl.load && (ds_count_ff != DS_MAX)) begin
         ds_count_in = ds_count_ff + DS_W'(1);
      end
      if (ctl.finish) begin
         emit_idx_in = '0;
      end else if (rsp_take) begin
         emit_idx_in = emit_idx_ff + IDX_W'(1);
      end
   end

   always_comb begin
      rsp_valid_in    = rsp_valid_ff;
      rsp_model_id_in = rsp_model_id_ff;
      rsp_rank_in     = rsp_rank_ff;
      rsp_sum_in      = rsp_sum_ff;
      rsp_ds_in       = rsp_ds_ff;
      rsp_last_in     = rsp_last_ff;
      if (rsp_take) begin
         rsp_valid_in    = 1'b1;
         rsp_model_id_in = INDEX_W'(emit_idx_ff);
         rsp_rank_in     = RANK_OUT_W'(emit_rank[0]);
         rsp_sum_in      = emit_sum[0];
         rsp_ds_in       = ds_count_ff;
         rsp_last_in     = emit_last;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         step_ff        <= '0;
         emit_idx_ff    <= '0;
         model_count_ff <= CFG_RESET;
         ds_count_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         step_ff        <= step_in;
         emit_idx_ff    <= emit_idx_in;
         model_count_ff <= model_count_in;
         ds_count_ff    <= ds_count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_model_id_ff <= rsp_model_id_in;
      rsp_rank_ff     <= rsp_rank_in;
      rsp_sum_ff      <= rsp_sum_in;
      rsp_ds_ff       <= rsp_ds_in;
      rsp_last_ff     <= rsp_last_in;
   end

   assign emit_rank[MAX_MODELS] = '0;
   assign emit_sum[MAX_MODELS]  = '0;

   for (genvar i = 0; i < MAX_MODELS; i++) begin : g_cell
      trsa_cell #(
         .MAX_MODELS (MAX_MODELS),
         .SCORE_BITS (SCORE_BITS)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .ctl           (ctl),
         .active        (int'(n_eff) > i),
         .wr_en         (req_take && (int'(req_model_index) == i)),
         .wr_score      (req_score),
         .nbr_score     (rot_score[(i+1) % MAX_MODELS]),
         .nbr_valid     (rot_valid[(i+1) % MAX_MODELS]),
         .rot_score_out (rot_score[i]),
         .rot_valid_out (rot_valid[i]),
         .chain_rank    (emit_rank[i+1]),
         .chain_sum     (emit_sum[i+1]),
         .emit_rank_out (emit_rank[i]),
         .emit_sum_out  (emit_sum[i])
      );
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_model_id         = rsp_model_id_ff;
   assign rsp_rank_doubled     = rsp_rank_ff;
   assign rsp_rank_sum_doubled = rsp_sum_ff;
   assign rsp_datasets_seen    = rsp_ds_ff;
   assign rsp_last_of_run      = rsp_last_ff;

endmodule

`default_nettype wire

FILE: design/trsa_checker.sv
`default_nettype none

module trsa_checker import trsa_pkg::*; (
   input wire                  clock,
   input wire                  reset,
   input wire                  req_valid,
   input wire                  req_stall,
   input wire                  req_last_in_dataset,
   input wire                  rsp_valid,
   input wire                  rsp_stall,
   input wire [INDEX_W-1:0]    rsp_model_id,
   input wire [RANK_OUT_W-1:0] rsp_rank_doubled,
   input wire [SUM_W-1:0]      rsp_rank_sum_doubled,
   input wire [DS_W-1:0]       rsp_datasets_seen,
   input wire                  rsp_last_of_run
);

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("block not idle after reset");

   a_last_starts_rank: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_last_in_dataset |=> req_stall)
      else $error("last beat did not start ranking");

   a_run_holds_input: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_of_run |-> req_stall)
      else $error("input open in the middle of a result run");

   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_datasets_seen != '0)
      else $error("result with zero dataset count");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_model_id)
         && $stable(rsp_rank_doubled) && $stable(rsp_rank_sum_doubled)
         && $stable(rsp_datasets_seen) && $stable(rsp_last_of_run))
      else $error("stalled result beat changed");

endmodule

bind tied_rank_sum_accumulator_top trsa_checker u_trsa_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_valid),
   .req_stall            (req_stall),
   .req_last_in_dataset  (req_last_in_dataset),
   .rsp_valid            (rsp_valid),
   .rsp_stall            (rsp_stall),
   .rsp_model_id         (rsp_model_id),
   .rsp_rank_doubled     (rsp_rank_doubled),
   .rsp_rank_sum_doubled (rsp_rank_sum_doubled),
   .rsp_datasets_seen    (rsp_datasets_seen),
   .rsp_last_of_run      (rsp_last_of_run)
);

`default_nettype wire

FILE: sim/rank_sum_checker.sv
module rank_sum_checker import trsa_pkg::*; #(
   parameter int MAX_MODELS = 16,
   parameter int SCORE_BITS = 16
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   input  wire                   req_stall,
   input  wire  [INDEX_W-1:0]    req_model_index,
   input  wire  [SCORE_BITS-1:0] req_score,
   input  wire                   req_last_in_dataset,
   input  wire                   rsp_valid,
   input  wire                   rsp_stall,
   input  wire  [INDEX_W-1:0]    rsp_model_id,
   input  wire  [RANK_OUT_W-1:0] rsp_rank_doubled,
   input  wire  [SUM_W-1:0]      rsp_rank_sum_doubled,
   input  wire  [DS_W-1:0]       rsp_datasets_seen,
   input  wire                   rsp_last_of_run,
   input  wire                   csr_valid,
   input  wire                   csr_ready,
   input  wire  [CFG_W-1:0]      csr_data,
   output int                    mismatch_count,
   output int                    waiting_count,
   output int                    checked_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [INDEX_W-1:0]    model_id;
      logic [RANK_OUT_W-1:0] rank_doubled;
      logic [SUM_W-1:0]      rank_sum;
      logic [DS_W-1:0]       seen;
      logic                  last_of_run;
   } model_rank_type;

   model_rank_type        rank_queue[$];
   logic [SCORE_BITS-1:0] scores [MAX_MODELS];
   logic [SUM_W-1:0]      sums [MAX_MODELS];
   logic [DS_W-1:0]       datasets;
   logic [CFG_W-1:0]      model_count;
   int                    errors = 0;
   int                    checked = 0;

   task automatic report_mismatch(input string what, input longint got, input longint want);
      errors++;
      if (errors <= 40)
         $display("%0t ns rank check: %s got %0d, expected %0d", $time, what, got, want);
   endtask

   task automatic rank_dataset();
      int             n;
      int             greater;
      int             equal;
      int             total;
      model_rank_type entry;
      n = int'(model_count);
      if (n < 1) n = 1;
      if (n > MAX_MODELS) n = MAX_MODELS;
      if (datasets != DS_MAX) datasets++;
      for (int i = 0; i < n; i++) begin
         greater = 0;
         equal   = 0;
         for (int j = 0; j < n; j++) begin
            if (scores[j] > scores[i]) greater++;
            else if (scores[j] == scores[i]) equal++;
         end
         total   = int'(sums[i]) + 2 * greater + equal + 1;
         sums[i] = (total > int'(SUM_MAX)) ? SUM_MAX : SUM_W'(total);
         entry.model_id     = INDEX_W'(i);
         entry.rank_doubled = RANK_OUT_W'(2 * greater + equal + 1);
         entry.rank_sum     = sums[i];
         entry.seen         = datasets;
         entry.last_of_run  = (i == n - 1);
         rank_queue = {rank_queue, entry};
      end
   endtask

   task automatic compare_result();
      model_rank_type want;
      if (rank_queue.size() == 0) begin
         report_mismatch("result beat with nothing pending, model_id", rsp_model_id, 0);
      end else begin
         want = rank_queue.pop_front();
         checked++;
         if (rsp_model_id !== want.model_id)
            report_mismatch("model_id", rsp_model_id, want.model_id);
         if (rsp_rank_doubled !== want.rank_doubled)
            report_mismatch("rank_doubled", rsp_rank_doubled, want.rank_doubled);
         if (rsp_rank_sum_doubled !== want.rank_sum)
            report_mismatch("rank_sum_doubled", rsp_rank_sum_doubled, want.rank_sum);
         if (rsp_datasets_seen !== want.seen)
            report_mismatch("datasets_seen", rsp_datasets_seen, want.seen);
         if (rsp_last_of_run !== want.last_of_run)
            report_mismatch("last_of_run", rsp_last_of_run, want.last_of_run);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rank_queue.delete();
         for (int i = 0; i < MAX_MODELS; i++) begin
            scores[i] = '0;
            sums[i]   = '0;
         end
         datasets    = '0;
         model_count = CFG_RESET;
      end else begin
         if (csr_valid && csr_ready) model_count = csr_data;
         if (rsp_valid && !rsp_stall) compare_result();
         if (req_valid && !req_stall) begin
            if (int'(req_model_index) < MAX_MODELS) scores[req_model_index] = req_score;
            if (req_last_in_dataset) rank_dataset();
         end
      end
      mismatch_count <= errors;
      waiting_count  <= rank_queue.size();
      checked_count  <= checked;
   end

endmodule

FILE: sim/tied_rank_sum_accumulator_top_tb.sv
module tied_rank_sum_accumulator_top_tb import trsa_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_MODELS    = 16;
   localparam int SCORE_BITS    = 16;
   localparam int SETTLE_CYCLES = 2 * MAX_MODELS + 4;
   localparam int LONG_HOLD     = 300;
   localparam int IDLE_LIMIT    = 2000;

   typedef enum int {
      SCORES_SPREAD,
      SCORES_CLOSE,
      SCORES_EDGE,
      SCORES_EQUAL
   } score_mix_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [INDEX_W-1:0]    req_model_index = '0;
   logic [SCORE_BITS-1:0] req_score = '0;
   logic                  req_last_in_dataset = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [INDEX_W-1:0]    rsp_model_id;
   logic [RANK_OUT_W-1:0] rsp_rank_doubled;
   logic [SUM_W-1:0]      rsp_rank_sum_doubled;
   logic [DS_W-1:0]       rsp_datasets_seen;
   logic                  rsp_last_of_run;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CFG_W-1:0]      csr_data = CFG_RESET;

   int                    checker_mismatches;
   int                    checker_waiting;
   int                    checker_checked;

   logic [MAX_MODELS-1:0] written_mask = '0;
   int                    active_n = MAX_MODELS;
   int                    burst_left = 0;
   int                    beats_sent = 0;
   int                    datasets_sent = 0;
   logic                  long_hold_req = 1'b0;

   wire req_fire = req_valid && !req_stall;
   wire rsp_fire = rsp_valid && !rsp_stall;
   wire csr_fire = csr_valid && csr_ready;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   tied_rank_sum_accumulator_top #(
      .MAX_MODELS (MAX_MODELS),
      .SCORE_BITS (SCORE_BITS)
   ) u_top (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_model_index      (req_model_index),
      .req_score            (req_score),
      .req_last_in_dataset  (req_last_in_dataset),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_model_id         (rsp_model_id),
      .rsp_rank_doubled     (rsp_rank_doubled),
      .rsp_rank_sum_doubled (rsp_rank_sum_doubled),
      .rsp_datasets_seen    (rsp_datasets_seen),
      .rsp_last_of_run      (rsp_last_of_run),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_data             (csr_data)
   );

   rank_sum_checker #(
      .MAX_MODELS (MAX_MODELS),
      .SCORE_BITS (SCORE_BITS)
   ) u_checker (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_model_index      (req_model_index),
      .req_score            (req_score),
      .req_last_in_dataset  (req_last_in_dataset),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_model_id         (rsp_model_id),
      .rsp_rank_doubled     (rsp_rank_doubled),
      .rsp_rank_sum_doubled (rsp_rank_sum_doubled),
      .rsp_datasets_seen    (rsp_datasets_seen),
      .rsp_last_of_run      (rsp_last_of_run),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_data             (csr_data),
      .mismatch_count       (checker_mismatches),
      .waiting_count        (checker_waiting),
      .checked_count        (checker_checked)
   );

   function automatic logic [SCORE_BITS-1:0] pick_score(input score_mix_type mix,
                                                        input logic [SCORE_BITS-1:0] shared);
      case (mix)
         SCORES_SPREAD: return SCORE_BITS'($urandom);
         SCORES_CLOSE:  return SCORE_BITS'($urandom_range(0, 3));
         SCORES_EDGE: begin
            case ($urandom_range(0, 3))
               0:       return '0;
               1:       return '1;
               2:       return SCORE_BITS'(1) << (SCORE_BITS - 1);
               default: return shared;
            endcase
         end
         default:       return shared;
      endcase
   endfunction

   function automatic logic ranking_allowed(input logic [INDEX_W-1:0] idx);
      logic [MAX_MODELS-1:0] need;
      need = MAX_MODELS'((17'd1 << active_n) - 1);
      return ((written_mask | (MAX_MODELS'(1) << idx)) & need) == need;
   endfunction

   task automatic send_score(input logic [INDEX_W-1:0] idx, input logic [SCORE_BITS-1:0] score,
                             input logic last);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
      end
      burst_left--;
      req_valid           <= 1'b1;
      req_model_index     <= idx;
      req_score           <= score;
      req_last_in_dataset <= last;
      do @(posedge clock); while (req_stall);
      written_mask[idx] = 1'b1;
      beats_sent++;
      if (last) datasets_sent++;
   endtask

   task automatic set_model_count(input logic [CFG_W-1:0] value);
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (checker_waiting != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      active_n = (value == 0) ? 1 : (int'(value) > MAX_MODELS) ? MAX_MODELS : int'(value);
   endtask

   task automatic run_dataset(input score_mix_type mix);
      int                    order[$];
      int                    j;
      int                    tmp;
      logic [SCORE_BITS-1:0] shared;
      shared = SCORE_BITS'($urandom);
      for (int m = 0; m < MAX_MODELS; m++)
         if ((m < active_n && (!written_mask[m] || $urandom_range(0, 5) != 0)) ||
             $urandom_range(0, 9) == 0)
            order = {order, m};
      if (order.size() == 0) order = {order, int'($urandom_range(0, active_n - 1))};
      for (int k = order.size() - 1; k > 0; k--) begin
         j        = $urandom_range(0, k);
         tmp      = order[k];
         order[k] = order[j];
         order[j] = tmp;
      end
      foreach (order[k])
         send_score(INDEX_W'(order[k]), pick_score(mix, shared), k == order.size() - 1);
   endtask

   task automatic random_traffic(input int beats);
      int                 stop_at;
      int                 next_cfg;
      logic [INDEX_W-1:0] idx;
      stop_at  = beats_sent + beats;
      next_cfg = beats_sent + $urandom_range(25, 60);
      while (beats_sent < stop_at) begin
         if (beats_sent >= next_cfg) begin
            case ($urandom_range(0, 5))
               0:       set_model_count('0);
               1:       set_model_count('1);
               2:       set_model_count(CFG_W'(MAX_MODELS));
               3:       set_model_count(CFG_W'($urandom_range(1, 3)));
               default: set_model_count(CFG_W'($urandom_range(0, 31)));
            endcase
            next_cfg = beats_sent + $urandom_range(25, 60);
         end
         if ($urandom_range(0, 4) == 0) begin
            idx = INDEX_W'($urandom_range(0, MAX_MODELS - 1));
            send_score(idx, SCORE_BITS'($urandom),
                       $urandom_range(0, 3) == 0 && ranking_allowed(idx));
         end else begin
            run_dataset(score_mix_type'($urandom_range(0, 3)));
         end
      end
   endtask

   initial begin : receiver
      int mode;
      bit hold_done;
      hold_done = 1'b0;
      forever begin
         if (long_hold_req && !hold_done) begin
            hold_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
         end
         mode = $urandom_range(0, 3);
         repeat ($urandom_range(8, 60)) begin
            case (mode)
               0:       rsp_stall <= 1'b0;
               1:       rsp_stall <= 1'($urandom_range(0, 1));
               2:       rsp_stall <= ($urandom_range(0, 9) < 8);
               default: rsp_stall <= ($urandom_range(0, 9) == 0);
            endcase
            @(posedge clock);
         end
      end
   end

   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || req_fire || rsp_fire || csr_fire) idle = 0;
         else idle++;
      end
      $display("[tied_rank_sum_accumulator_top] ERROR");
      $finish;
   end

   initial begin : stimulus
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      set_model_count(CFG_W'(3));
      send_score(0, 16'h0000, 1'b0);
      send_score(1, 16'hFFFF, 1'b0);
      send_score(2, 16'hFFFF, 1'b1);
      send_score(2, 16'h1234, 1'b0);
      send_score(0, 16'h1234, 1'b0);
      send_score(1, 16'h1234, 1'b1);
      send_score(1, 16'h0001, 1'b1);
      set_model_count('0);
      send_score(0, 16'hA5A5, 1'b1);
      set_model_count(CFG_W'(2));
      send_score(12, 16'h5A5A, 1'b0);
      send_score(1, 16'h0000, 1'b1);
      set_model_count('1);
      for (int m = 0; m < MAX_MODELS; m++)
         send_score(INDEX_W'(m), (m == 9) ? 16'hFFFF - 16'h8888 : 16'hFFFF - 16'(m) * 16'h1111,
                    m == MAX_MODELS - 1);

      long_hold_req = 1'b1;
      random_traffic(330);
      random_traffic(30);

      req_valid <= 1'b0;
      @(posedge clock);
      while (checker_waiting != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Sent %0d score beats forming %0d ranked datasets; %0d model results checked.",
               beats_sent, datasets_sent, checker_checked);
      $display("Model counts 0 to 31 with clamping, ties, stale scores and long stalls covered.");
      if (checker_mismatches == 0)
         $display("[tied_rank_sum_accumulator_top] OK");
      else
         $display("[tied_rank_sum_accumulator_top] ERROR");
      $finish;
   end

endmodule

FILE: filelist.f
design/trsa_pkg.sv
design/trsa_cell.sv
design/tied_rank_sum_accumulator_top.sv
design/trsa_checker.sv
sim/rank_sum_checker.sv
sim/tied_rank_sum_accumulator_top_tb.sv
